// ===== design/mmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the min/max decimation block.
// No dependencies.
package mmd_pkg;

  localparam int SAMPLE_BITS_DEF    = 32;
  localparam int INDEX_BITS_DEF     = 40;
  localparam int LINE_THRESHOLD_DEF = 2;

  localparam int X_BITS         = 48;
  localparam int BASE_BITS      = 64;
  localparam int SHIFT_BITS     = 6;
  localparam int CFG_INDEX_BITS = 2;
  localparam int JOB_DEPTH      = 4;
  localparam int VTX_DEPTH      = 4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUCKET_SHIFT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_SHIFT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIEW_BEGIN   = 2'd2;

  typedef enum logic [1:0] {
    VK_LINE = 2'd0,
    VK_CONN = 2'd1,
    VK_BAR  = 2'd2
  } vkind_e;

  // Classification of one accepted entry, from front to back.
  typedef struct packed {
    logic line;        // line-strip mode
    logic new_bucket;  // entry opens a fresh bucket
    logic close;       // entry closes its bucket
    logic fin;         // last entry of the view
  } job_ctl_t;

endpackage

// ===== design/mmd_fifo.sv =====
`timescale 1ns / 1ps
// Small show-ahead queue with registered storage.
// Used between front and back and in front of the result ports; needs no package.
module mmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/mmd_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies each accepted entry (line mode, bucket open/close)
// and tracks the open bucket's start index. Depends on mmd_pkg.
module mmd_front #(
  parameter int INDEX_BITS     = mmd_pkg::INDEX_BITS_DEF,
  parameter int SAMPLE_BITS    = mmd_pkg::SAMPLE_BITS_DEF,
  parameter int LINE_THRESHOLD = mmd_pkg::LINE_THRESHOLD_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mmd_pkg::SHIFT_BITS-1:0]      bucket_shift_i,
  input  logic [mmd_pkg::SHIFT_BITS-1:0]      level_shift_i,
  input  logic                                accept_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_low_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_high_i,
  input  logic [INDEX_BITS-1:0]               entry_index_i,
  input  logic                                final_entry_i,
  output mmd_pkg::job_ctl_t                   job_ctl_o,
  output logic signed [SAMPLE_BITS-1:0]       job_lo_o,
  output logic signed [SAMPLE_BITS-1:0]       job_hi_o,
  output logic [INDEX_BITS-1:0]               job_pos_o
);
  import mmd_pkg::*;

  logic                  bucket_open_q, bucket_open_d;
  logic [INDEX_BITS-1:0] bucket_start_q, bucket_start_d;
  logic [SHIFT_BITS-1:0] ls_c, d_shift;
  logic [INDEX_BITS-1:0] low_mask, start_eff;
  logic                  line_mode, same_bucket, new_bucket, close;

  always_comb begin
    ls_c        = (level_shift_i > bucket_shift_i) ? bucket_shift_i : level_shift_i;
    line_mode   = (ls_c == '0) && (bucket_shift_i < SHIFT_BITS'(LINE_THRESHOLD));
    d_shift     = bucket_shift_i - ls_c;
    low_mask    = ~({INDEX_BITS{1'b1}} << d_shift);
    same_bucket = ((entry_index_i ^ bucket_start_q) & ~low_mask) == '0;
    new_bucket  = !bucket_open_q || !same_bucket;
    // a bucket wider than the index space never reaches its last index
    close       = final_entry_i ||
                  ((int'(d_shift) <= INDEX_BITS) && ((entry_index_i & low_mask) == low_mask));
    start_eff   = new_bucket ? (entry_index_i & ~low_mask) : bucket_start_q;

    job_ctl_o.line       = line_mode;
    job_ctl_o.new_bucket = new_bucket;
    job_ctl_o.close      = close;
    job_ctl_o.fin        = final_entry_i;
    job_lo_o             = sample_low_i;
    // raw samples carry their value in the low field only
    job_hi_o             = (ls_c == '0) ? sample_low_i : sample_high_i;
    job_pos_o            = line_mode ? entry_index_i : start_eff;
  end

  always_comb begin
    bucket_open_d  = bucket_open_q;
    bucket_start_d = bucket_start_q;
    if (accept_i) begin
      if (line_mode) begin
        if (final_entry_i) begin
          bucket_open_d = 1'b0;
        end
      end else begin
        bucket_open_d  = !close;
        bucket_start_d = start_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_open_q  <= 1'b0;
      bucket_start_q <= '0;
    end else begin
      bucket_open_q  <= bucket_open_d;
      bucket_start_q <= bucket_start_d;
    end
  end

endmodule

// ===== design/mmd_back.sv =====
`timescale 1ns / 1ps
// Back end: running min/max, previous bucket, and the vertex emitter that
// expands a closed bucket or a line point into one to four vertices. Depends on mmd_pkg.
module mmd_back #(
  parameter int INDEX_BITS  = mmd_pkg::INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [mmd_pkg::SHIFT_BITS-1:0]       bucket_shift_i,
  input  logic [mmd_pkg::SHIFT_BITS-1:0]       level_shift_i,
  input  logic signed [mmd_pkg::X_BITS-1:0]    view_begin_i,
  input  logic                                 job_valid_i,
  output logic                                 job_pop_o,
  input  mmd_pkg::job_ctl_t                    job_ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]        job_lo_i,
  input  logic signed [SAMPLE_BITS-1:0]        job_hi_i,
  input  logic [INDEX_BITS-1:0]                job_pos_i,
  input  logic                                 vtx_full_i,
  output logic                                 vtx_push_o,
  output logic signed [mmd_pkg::X_BITS-1:0]    vtx_x_o,
  output logic signed [SAMPLE_BITS-1:0]        vtx_y_o,
  output mmd_pkg::vkind_e                      vtx_kind_o,
  output logic                                 vtx_last_o
);
  import mmd_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] MAX_VAL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [1:0] STEP_CONN0 = 2'd0;
  localparam logic [1:0] STEP_CONN1 = 2'd1;
  localparam logic [1:0] STEP_BAR0  = 2'd2;
  localparam logic [1:0] STEP_LAST  = 2'd3;

  // bucket accumulation
  logic signed [SAMPLE_BITS-1:0] run_min_q, run_min_d, run_max_q, run_max_d;
  logic signed [SAMPLE_BITS-1:0] prev_min_q, prev_min_d, prev_max_q, prev_max_d;
  logic                          prev_valid_q, prev_valid_d;
  logic signed [SAMPLE_BITS-1:0] nmin, nmax;
  logic                          need_emit, job_take;

  // capture stage
  logic                          e1_valid_q, e1_valid_d;
  logic                          e1_line_q, e1_pvalid_q;
  logic [INDEX_BITS-1:0]         e1_pos_q;
  logic signed [SAMPLE_BITS-1:0] e1_min_q, e1_max_q, e1_pmin_q, e1_pmax_q;
  logic                          e1_free, e1_move;

  // emit stage
  logic                          e2_valid_q, e2_valid_d;
  logic [1:0]                    e2_step_q, e2_step_d;
  logic                          e2_line_q;
  logic [BASE_BITS-1:0]          e2_base_q;
  logic signed [SAMPLE_BITS-1:0] e2_midp_q, e2_midc_q, e2_min_q, e2_max_q;
  logic                          e2_free, e2_done;

  // capture-to-emit arithmetic
  logic [SHIFT_BITS-1:0]         ls_c;
  logic [BASE_BITS-1:0]          half, pos64, vb64, base_calc;
  logic                          conn_calc;
  logic signed [SAMPLE_BITS:0]   sum_p, sum_c;
  logic [BASE_BITS-1:0]          base_sel;
  logic signed [BASE_BITS-1:0]   x_full;

  assign need_emit = job_ctl_i.line || job_ctl_i.close;
  assign e2_done   = vtx_push_o && (e2_step_q == STEP_LAST);
  assign e2_free   = !e2_valid_q || e2_done;
  assign e1_move   = e1_valid_q && e2_free;
  assign e1_free   = !e1_valid_q || e1_move;
  assign job_pop_o = job_valid_i && (!need_emit || e1_free);
  assign job_take  = job_pop_o;

  always_comb begin
    if (job_ctl_i.new_bucket) begin
      nmin = job_lo_i;
      nmax = job_hi_i;
    end else begin
      nmin = (job_lo_i < run_min_q) ? job_lo_i : run_min_q;
      nmax = (run_max_q < job_hi_i) ? job_hi_i : run_max_q;
    end
  end

  always_comb begin
    run_min_d    = run_min_q;
    run_max_d    = run_max_q;
    prev_min_d   = prev_min_q;
    prev_max_d   = prev_max_q;
    prev_valid_d = prev_valid_q;
    if (job_take) begin
      if (job_ctl_i.line) begin
        if (job_ctl_i.fin) begin
          prev_valid_d = 1'b0;
          run_min_d    = MAX_VAL;
          run_max_d    = MIN_VAL;
        end
      end else if (job_ctl_i.close) begin
        prev_min_d   = nmin;
        prev_max_d   = nmax;
        prev_valid_d = !job_ctl_i.fin;
        run_min_d    = MAX_VAL;
        run_max_d    = MIN_VAL;
      end else begin
        run_min_d = nmin;
        run_max_d = nmax;
      end
    end
  end

  always_comb begin
    ls_c      = (level_shift_i > bucket_shift_i) ? bucket_shift_i : level_shift_i;
    half      = (bucket_shift_i == '0) ? '0
              : (BASE_BITS'(1) << (bucket_shift_i - SHIFT_BITS'(1)));
    pos64     = BASE_BITS'(e1_pos_q);
    vb64      = {{(BASE_BITS-X_BITS){view_begin_i[X_BITS-1]}}, view_begin_i};
    base_calc = e1_line_q ? (pos64 - vb64) : ((pos64 << ls_c) + half - vb64);
    // touching ranges count as disjoint
    conn_calc = e1_pvalid_q && (!(e1_min_q < e1_pmax_q) || !(e1_pmin_q < e1_max_q));
    sum_p     = {e1_pmin_q[SAMPLE_BITS-1], e1_pmin_q} + {e1_pmax_q[SAMPLE_BITS-1], e1_pmax_q};
    sum_c     = {e1_min_q[SAMPLE_BITS-1], e1_min_q} + {e1_max_q[SAMPLE_BITS-1], e1_max_q};
  end

  always_comb begin
    e1_valid_d = e1_valid_q;
    if (job_take && need_emit) begin
      e1_valid_d = 1'b1;
    end else if (e1_move) begin
      e1_valid_d = 1'b0;
    end
    e2_valid_d = e2_valid_q;
    e2_step_d  = e2_step_q;
    if (e1_move) begin
      e2_valid_d = 1'b1;
      e2_step_d  = e1_line_q ? STEP_LAST : (conn_calc ? STEP_CONN0 : STEP_BAR0);
    end else if (e2_done) begin
      e2_valid_d = 1'b0;
    end else if (vtx_push_o) begin
      e2_step_d = e2_step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q    <= MAX_VAL;
      run_max_q    <= MIN_VAL;
      prev_min_q   <= '0;
      prev_max_q   <= '0;
      prev_valid_q <= 1'b0;
      e1_valid_q   <= 1'b0;
      e2_valid_q   <= 1'b0;
      e2_step_q    <= STEP_LAST;
    end else begin
      run_min_q    <= run_min_d;
      run_max_q    <= run_max_d;
      prev_min_q   <= prev_min_d;
      prev_max_q   <= prev_max_d;
      prev_valid_q <= prev_valid_d;
      e1_valid_q   <= e1_valid_d;
      e2_valid_q   <= e2_valid_d;
      e2_step_q    <= e2_step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take && need_emit) begin
      e1_line_q   <= job_ctl_i.line;
      e1_pos_q    <= job_pos_i;
      e1_min_q    <= job_ctl_i.line ? job_lo_i : nmin;
      e1_max_q    <= job_ctl_i.line ? job_lo_i : nmax;
      e1_pmin_q   <= prev_min_q;
      e1_pmax_q   <= prev_max_q;
      e1_pvalid_q <= prev_valid_q;
    end
    if (e1_move) begin
      e2_line_q <= e1_line_q;
      e2_base_q <= base_calc;
      e2_midp_q <= sum_p[SAMPLE_BITS:1];
      e2_midc_q <= sum_c[SAMPLE_BITS:1];
      e2_min_q  <= e1_min_q;
      e2_max_q  <= e1_max_q;
    end
  end

  // vertex select, one per cycle while the result queue has room
  always_comb begin
    base_sel   = (e2_step_q == STEP_CONN0) ? (e2_base_q - BASE_BITS'(1)) : e2_base_q;
    x_full     = $signed(base_sel) >>> bucket_shift_i;
    vtx_x_o    = x_full[X_BITS-1:0];
    vtx_push_o = e2_valid_q && !vtx_full_i;
    vtx_last_o = (e2_step_q == STEP_LAST);
    case (e2_step_q)
      STEP_CONN0: begin
        vtx_y_o    = e2_midp_q;
        vtx_kind_o = VK_CONN;
      end
      STEP_CONN1: begin
        vtx_y_o    = e2_midc_q;
        vtx_kind_o = VK_CONN;
      end
      STEP_BAR0: begin
        vtx_y_o    = e2_min_q;
        vtx_kind_o = VK_BAR;
      end
      default: begin
        vtx_y_o    = e2_max_q;
        vtx_kind_o = e2_line_q ? VK_LINE : VK_BAR;
      end
    endcase
  end

endmodule

// ===== design/minmax_decimation_plot_vertices.sv =====
`timescale 1ns / 1ps
// Top level of the min/max decimation block: configuration registers, front end,
// job queue, back end and result queue. Depends on mmd_pkg, mmd_fifo, mmd_front, mmd_back.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  input     | push / full            | sample_low_i sample_high_i entry_index_i final_entry_i
//  result    | empty / pop            | x_coord_o y_coord_o vertex_kind_o last_of_run_o
//  config    | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// One entry is accepted per cycle. A line point or a closed bucket becomes 1, 2 or 4
// vertices, written one per cycle by the back-end emitter; that emitter sets the
// sustained rate when closing buckets yield more vertices than entries arrive. A result
// passes the job queue, the capture and emit stages and the result queue before it
// reaches the ports. Reset clears all control state at once, no clearing pass. full rises
// when the 4-entry job queue fills; the emitter holds when the 4-entry result queue is full.
module minmax_decimation_plot_vertices #(
  parameter int SAMPLE_BITS    = mmd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS     = mmd_pkg::INDEX_BITS_DEF,
  parameter int LINE_THRESHOLD = mmd_pkg::LINE_THRESHOLD_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [SAMPLE_BITS-1:0]         sample_low_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_high_i,
  input  logic [INDEX_BITS-1:0]                 entry_index_i,
  input  logic                                  final_entry_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [mmd_pkg::X_BITS-1:0]     x_coord_o,
  output logic signed [SAMPLE_BITS-1:0]         y_coord_o,
  output logic [1:0]                            vertex_kind_o,
  output logic                                  last_of_run_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mmd_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [mmd_pkg::X_BITS-1:0]            cfg_data_i
);
  import mmd_pkg::*;

  localparam int CTL_W = $bits(job_ctl_t);
  localparam int JOB_W = CTL_W + 2 * SAMPLE_BITS + INDEX_BITS;
  localparam int VTX_W = X_BITS + SAMPLE_BITS + 2 + 1;

  logic [SHIFT_BITS-1:0]         bucket_shift_q, level_shift_q;
  logic signed [X_BITS-1:0]      view_begin_q;

  logic                          accept;
  job_ctl_t                      f_ctl, b_ctl;
  logic signed [SAMPLE_BITS-1:0] f_lo, f_hi, b_lo, b_hi;
  logic [INDEX_BITS-1:0]         f_pos, b_pos;
  logic [JOB_W-1:0]              job_wdata, job_rdata;
  logic                          job_empty, job_pop;

  logic                          vtx_push, vtx_full, vtx_last;
  logic signed [X_BITS-1:0]      vtx_x;
  logic signed [SAMPLE_BITS-1:0] vtx_y;
  vkind_e                        vtx_kind;
  logic [VTX_W-1:0]              vtx_wdata, vtx_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_shift_q <= '0;
      level_shift_q  <= '0;
      view_begin_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BUCKET_SHIFT: bucket_shift_q <= cfg_data_i[SHIFT_BITS-1:0];
        CFG_LEVEL_SHIFT:  level_shift_q  <= cfg_data_i[SHIFT_BITS-1:0];
        CFG_VIEW_BEGIN:   view_begin_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  mmd_front #(
    .INDEX_BITS    (INDEX_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .LINE_THRESHOLD(LINE_THRESHOLD)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bucket_shift_i(bucket_shift_q),
    .level_shift_i (level_shift_q),
    .accept_i      (accept),
    .sample_low_i  (sample_low_i),
    .sample_high_i (sample_high_i),
    .entry_index_i (entry_index_i),
    .final_entry_i (final_entry_i),
    .job_ctl_o     (f_ctl),
    .job_lo_o      (f_lo),
    .job_hi_o      (f_hi),
    .job_pos_o     (f_pos)
  );

  assign job_wdata = {f_ctl, f_lo, f_hi, f_pos};

  mmd_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(job_wdata),
    .full_o (full),
    .pop_i  (job_pop),
    .rdata_o(job_rdata),
    .empty_o(job_empty)
  );

  assign {b_ctl, b_lo, b_hi, b_pos} = job_rdata;

  mmd_back #(
    .INDEX_BITS (INDEX_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bucket_shift_i(bucket_shift_q),
    .level_shift_i (level_shift_q),
    .view_begin_i  (view_begin_q),
    .job_valid_i   (!job_empty),
    .job_pop_o     (job_pop),
    .job_ctl_i     (b_ctl),
    .job_lo_i      (b_lo),
    .job_hi_i      (b_hi),
    .job_pos_i     (b_pos),
    .vtx_full_i    (vtx_full),
    .vtx_push_o    (vtx_push),
    .vtx_x_o       (vtx_x),
    .vtx_y_o       (vtx_y),
    .vtx_kind_o    (vtx_kind),
    .vtx_last_o    (vtx_last)
  );

  assign vtx_wdata = {vtx_x, vtx_y, 2'(vtx_kind), vtx_last};

  mmd_fifo #(
    .WIDTH(VTX_W),
    .DEPTH(VTX_DEPTH)
  ) u_vtx_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (vtx_push),
    .wdata_i(vtx_wdata),
    .full_o (vtx_full),
    .pop_i  (pop),
    .rdata_o(vtx_rdata),
    .empty_o(empty)
  );

  assign {x_coord_o, y_coord_o, vertex_kind_o, last_of_run_o} = vtx_rdata;

endmodule

// ===== design/mmd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the min/max decimation block, bound to the top level.
// Depends on mmd_pkg.
module mmd_checker #(
  parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic signed [mmd_pkg::X_BITS-1:0] x_coord_o,
  input logic signed [SAMPLE_BITS-1:0]     y_coord_o,
  input logic [1:0]                        vertex_kind_o,
  input logic                              last_of_run_o
);
  import mmd_pkg::*;

  // nothing to deliver in the cycle after a reset edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // hold the waiting word until it is taken
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(x_coord_o) && $stable(y_coord_o)
                          && $stable(vertex_kind_o) && $stable(last_of_run_o)))
    else $error("waiting result changed before pop");

  // a line point is always the single vertex of its entry
  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && vertex_kind_o == VK_LINE) |-> last_of_run_o)
    else $error("line vertex without last flag");

  // a connector is never the closing vertex
  a_conn_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && vertex_kind_o == VK_CONN) |-> !last_of_run_o)
    else $error("connector vertex flagged last");

  // the max bar end follows the min bar end at the same column
  a_bar_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((!empty && pop && vertex_kind_o == VK_BAR && !last_of_run_o) ##1 !empty)
      |-> (vertex_kind_o == VK_BAR && last_of_run_o && x_coord_o == $past(x_coord_o)))
    else $error("bar ends not paired");

endmodule

bind minmax_decimation_plot_vertices mmd_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mmd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .x_coord_o    (x_coord_o),
  .y_coord_o    (y_coord_o),
  .vertex_kind_o(vertex_kind_o),
  .last_of_run_o(last_of_run_o)
);
